// File: rtl/core/qalu_pkg.sv
package qalu_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;
    localparam int EPS_WIDTH  = 15;
    localparam int NUM_COMP   = 4;

    // full product, rounded product, and sum of four rounded products
    localparam int PROD_W = 2 * COMP_WIDTH;
    localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W  = RND_W + 2;
    localparam int EXT_W  = COMP_WIDTH + 1;

    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);
    localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_CONJ = 2'd1,
        OP_NEG  = 2'd2,
        OP_CMP  = 2'd3
    } t_op;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [PROD_W:0]       t_prod_ext;
    typedef logic signed [RND_W-1:0]      t_rnd;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic signed [EXT_W-1:0]      t_ext;
    typedef logic        [EXT_W-1:0]      t_mag;

endpackage

// File: rtl/core/quaternion_alu_core.sv
// Quaternion ALU in signed Q2.14 fixed point: multiply (Hamilton product), conjugate,
// negate and approximate compare against the epsilon register. The block is a
// five-stage pipeline (input register, 16 parallel 16x16 multipliers, rounding,
// four-term sums, saturation into the output register), and one item can be taken every
// cycle while the output is not stalled. Each stage only holds when it is full and the
// stage after it holds, so bubbles close up under output stall. The epsilon register
// resets to 1 and is written through the configuration channel, which is always
// ready; write it only while no item is in flight.
module quaternion_alu_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_opcode,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_w,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_w,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [qalu_pkg::COMP_WIDTH-1:0] o_res_x,
    output logic signed [qalu_pkg::COMP_WIDTH-1:0] o_res_y,
    output logic signed [qalu_pkg::COMP_WIDTH-1:0] o_res_z,
    output logic signed [qalu_pkg::COMP_WIDTH-1:0] o_res_w,
    output logic                                   o_equal_flag,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [qalu_pkg::EPS_WIDTH-1:0]         i_cfg_data
);
    import qalu_pkg::*;

    logic [EPS_WIDTH-1:0] r_eps;

    // stage enables
    logic en1, en2, en3, en4, en5;

    // stage 1: input register
    logic  r_s1_v;
    t_op   r_s1_op;
    t_comp r_s1_a [NUM_COMP];
    t_comp r_s1_b [NUM_COMP];

    // stage 2: products, unary results, differences
    logic  r_s2_v;
    t_op   r_s2_op;
    t_prod r_s2_prod [NUM_COMP][NUM_COMP];
    t_ext  r_s2_un   [NUM_COMP];
    t_ext  r_s2_diff [NUM_COMP];
    t_prod n_s2_prod [NUM_COMP][NUM_COMP];
    t_ext  n_s2_un   [NUM_COMP];
    t_ext  n_s2_diff [NUM_COMP];

    // stage 3: rounded products, magnitudes
    logic  r_s3_v;
    t_op   r_s3_op;
    t_rnd  r_s3_rnd [NUM_COMP][NUM_COMP];
    t_ext  r_s3_un  [NUM_COMP];
    t_mag  r_s3_mag [NUM_COMP];
    t_rnd  n_s3_rnd [NUM_COMP][NUM_COMP];
    t_mag  n_s3_mag [NUM_COMP];

    // stage 4: unsaturated components, compare flag
    logic  r_s4_v;
    t_op   r_s4_op;
    t_sum  r_s4_sum [NUM_COMP];
    logic  r_s4_eq;
    t_sum  n_s4_sum [NUM_COMP];
    logic  n_s4_eq;

    // stage 5: output register
    logic  r_s5_v;
    t_comp r_s5_res [NUM_COMP];
    logic  r_s5_eq;
    logic  r_s5_sat;
    t_comp n_s5_res [NUM_COMP];
    logic  n_s5_sat;

    assign en5 = !r_s5_v || !i_out_stall;
    assign en4 = !r_s4_v || en5;
    assign en3 = !r_s3_v || en4;
    assign en2 = !r_s2_v || en3;
    assign en1 = !r_s1_v || en2;

    assign o_in_stall  = !en1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_in_valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
            if (en5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op   <= t_op'(i_opcode);
            r_s1_a[0] <= i_a_x;
            r_s1_a[1] <= i_a_y;
            r_s1_a[2] <= i_a_z;
            r_s1_a[3] <= i_a_w;
            r_s1_b[0] <= i_b_x;
            r_s1_b[1] <= i_b_y;
            r_s1_b[2] <= i_b_z;
            r_s1_b[3] <= i_b_w;
        end
    end

    // products per component; the last three terms of w and the last of x,y,z subtract
    always_comb begin
        n_s2_prod[0][0] = t_prod'(r_s1_a[3]) * t_prod'(r_s1_b[0]);
        n_s2_prod[0][1] = t_prod'(r_s1_b[3]) * t_prod'(r_s1_a[0]);
        n_s2_prod[0][2] = t_prod'(r_s1_b[1]) * t_prod'(r_s1_a[2]);
        n_s2_prod[0][3] = t_prod'(r_s1_b[2]) * t_prod'(r_s1_a[1]);
        n_s2_prod[1][0] = t_prod'(r_s1_a[3]) * t_prod'(r_s1_b[1]);
        n_s2_prod[1][1] = t_prod'(r_s1_b[3]) * t_prod'(r_s1_a[1]);
        n_s2_prod[1][2] = t_prod'(r_s1_b[2]) * t_prod'(r_s1_a[0]);
        n_s2_prod[1][3] = t_prod'(r_s1_b[0]) * t_prod'(r_s1_a[2]);
        n_s2_prod[2][0] = t_prod'(r_s1_a[3]) * t_prod'(r_s1_b[2]);
        n_s2_prod[2][1] = t_prod'(r_s1_b[3]) * t_prod'(r_s1_a[2]);
        n_s2_prod[2][2] = t_prod'(r_s1_b[0]) * t_prod'(r_s1_a[1]);
        n_s2_prod[2][3] = t_prod'(r_s1_b[1]) * t_prod'(r_s1_a[0]);
        n_s2_prod[3][0] = t_prod'(r_s1_a[3]) * t_prod'(r_s1_b[3]);
        n_s2_prod[3][1] = t_prod'(r_s1_a[0]) * t_prod'(r_s1_b[0]);
        n_s2_prod[3][2] = t_prod'(r_s1_a[1]) * t_prod'(r_s1_b[1]);
        n_s2_prod[3][3] = t_prod'(r_s1_a[2]) * t_prod'(r_s1_b[2]);
        for (int i = 0; i < NUM_COMP; i++) begin
            // conjugate keeps the scalar part
            if (r_s1_op == OP_CONJ && i == NUM_COMP - 1) begin
                n_s2_un[i] = t_ext'(r_s1_a[i]);
            end else begin
                n_s2_un[i] = -t_ext'(r_s1_a[i]);
            end
            n_s2_diff[i] = t_ext'(r_s1_a[i]) - t_ext'(r_s1_b[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_op   <= r_s1_op;
            r_s2_prod <= n_s2_prod;
            r_s2_un   <= n_s2_un;
            r_s2_diff <= n_s2_diff;
        end
    end

    // round to nearest, ties toward +inf
    always_comb begin
        t_prod_ext biased;
        for (int i = 0; i < NUM_COMP; i++) begin
            for (int j = 0; j < NUM_COMP; j++) begin
                biased         = t_prod_ext'(r_s2_prod[i][j]) + RND_HALF;
                n_s3_rnd[i][j] = biased[PROD_W:FRAC_BITS];
            end
            n_s3_mag[i] = r_s2_diff[i][EXT_W-1] ? t_mag'(-r_s2_diff[i])
                                                : t_mag'(r_s2_diff[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_op  <= r_s2_op;
            r_s3_rnd <= n_s3_rnd;
            r_s3_un  <= r_s2_un;
            r_s3_mag <= n_s3_mag;
        end
    end

    always_comb begin
        n_s4_eq = (r_s3_op == OP_CMP);
        for (int i = 0; i < NUM_COMP; i++) begin
            if (!(r_s3_mag[i] < t_mag'(r_eps))) n_s4_eq = 1'b0;
        end
        for (int i = 0; i < NUM_COMP; i++) begin
            unique case (r_s3_op) inside
                OP_MUL: begin
                    if (i == NUM_COMP - 1) begin
                        n_s4_sum[i] = t_sum'(r_s3_rnd[i][0]) - t_sum'(r_s3_rnd[i][1])
                                    - t_sum'(r_s3_rnd[i][2]) - t_sum'(r_s3_rnd[i][3]);
                    end else begin
                        n_s4_sum[i] = t_sum'(r_s3_rnd[i][0]) + t_sum'(r_s3_rnd[i][1])
                                    + t_sum'(r_s3_rnd[i][2]) - t_sum'(r_s3_rnd[i][3]);
                    end
                end
                OP_CONJ, OP_NEG: n_s4_sum[i] = t_sum'(r_s3_un[i]);
                default:         n_s4_sum[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_op  <= r_s3_op;
            r_s4_sum <= n_s4_sum;
            r_s4_eq  <= n_s4_eq;
        end
    end

    // clip when the bits above the sign are not all copies of it
    always_comb begin
        n_s5_sat = 1'b0;
        for (int i = 0; i < NUM_COMP; i++) begin
            if (r_s4_sum[i][SUM_W-1:COMP_WIDTH-1] != {(SUM_W - COMP_WIDTH + 1){1'b0}} &&
                r_s4_sum[i][SUM_W-1:COMP_WIDTH-1] != {(SUM_W - COMP_WIDTH + 1){1'b1}}) begin
                n_s5_sat    = 1'b1;
                n_s5_res[i] = r_s4_sum[i][SUM_W-1] ? {1'b1, {(COMP_WIDTH - 1){1'b0}}}
                                                   : {1'b0, {(COMP_WIDTH - 1){1'b1}}};
            end else begin
                n_s5_res[i] = r_s4_sum[i][COMP_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_res <= n_s5_res;
            r_s5_eq  <= r_s4_eq;
            r_s5_sat <= n_s5_sat;
        end
    end

    assign o_out_valid  = r_s5_v;
    assign o_res_x      = r_s5_res[0];
    assign o_res_y      = r_s5_res[1];
    assign o_res_z      = r_s5_res[2];
    assign o_res_w      = r_s5_res[3];
    assign o_equal_flag = r_s5_eq;
    assign o_saturated  = r_s5_sat;

    a_eq_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_equal_flag |-> !o_saturated && o_res_x == '0 && o_res_y == '0
                                        && o_res_z == '0 && o_res_w == '0)
        else $error("equal flag with nonzero result or saturation");

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_s5_v)
        else $error("input stalled while pipeline has a free slot");

    a_take_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_s1_v)
        else $error("transferred item missing from first stage");

    a_cmp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v && r_s4_op == OP_CMP |-> r_s4_sum[0] == '0 && r_s4_sum[1] == '0
                                        && r_s4_sum[2] == '0 && r_s4_sum[3] == '0)
        else $error("compare carries nonzero components");

    a_hold_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v && !en5 |=> r_s4_v && r_s5_v)
        else $error("item lost while output stalled");

endmodule

// File: verif/qalu_checker.sv
`timescale 1ns / 1ps

module qalu_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [1:0]                             i_opcode,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_a_w,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_b_w,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_res_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_res_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_res_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] i_res_w,
    input  logic                                   i_equal_flag,
    input  logic                                   i_saturated,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [qalu_pkg::EPS_WIDTH-1:0]         i_cfg_data,
    output int                                     o_pending,
    output int                                     o_fail_count
);

    import qalu_pkg::*;

    localparam longint COMP_MAX_L = (longint'(1) << (COMP_WIDTH - 1)) - 1;
    localparam longint COMP_MIN_L = -COMP_MAX_L - 1;

    typedef struct {
        t_comp x;
        t_comp y;
        t_comp z;
        t_comp w;
        logic  eq;
        logic  sat;
    } t_quat_result;

    t_quat_result             result_q[$];
    logic [EPS_WIDTH-1:0]     eps_reg = EPS_RESET;
    int                       pending_cnt = 0;
    int                       fail_cnt = 0;

    assign o_pending    = pending_cnt;
    assign o_fail_count = fail_cnt;

    // fixed-point product rounded to nearest, ties toward +inf
    function automatic longint round_mul(longint p, longint q);
        return (p * q + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_quat_result hamilton_predict(
        t_op op, t_comp qax, t_comp qay, t_comp qaz, t_comp qaw,
        t_comp qbx, t_comp qby, t_comp qbz, t_comp qbw, logic [EPS_WIDTH-1:0] eps
    );
        longint       ax, ay, az, aw, bx, by, bz, bw, tol;
        longint       r [4];
        t_quat_result res;
        ax = qax; ay = qay; az = qaz; aw = qaw;
        bx = qbx; by = qby; bz = qbz; bw = qbw;
        tol = longint'(eps);
        for (int i = 0; i < NUM_COMP; i++) r[i] = 0;
        res.eq  = 1'b0;
        res.sat = 1'b0;
        case (op)
            OP_MUL: begin
                // operand order of the cross term is b x a
                r[0] = round_mul(aw, bx) + round_mul(bw, ax)
                     + round_mul(by, az) - round_mul(bz, ay);
                r[1] = round_mul(aw, by) + round_mul(bw, ay)
                     + round_mul(bz, ax) - round_mul(bx, az);
                r[2] = round_mul(aw, bz) + round_mul(bw, az)
                     + round_mul(bx, ay) - round_mul(by, ax);
                r[3] = round_mul(aw, bw) - round_mul(ax, bx)
                     - round_mul(ay, by) - round_mul(az, bz);
            end
            OP_CONJ: begin
                r[0] = -ax; r[1] = -ay; r[2] = -az; r[3] = aw;
            end
            OP_NEG: begin
                r[0] = -ax; r[1] = -ay; r[2] = -az; r[3] = -aw;
            end
            default: begin
                res.eq = (mag(ax - bx) < tol) && (mag(ay - by) < tol) &&
                         (mag(az - bz) < tol) && (mag(aw - bw) < tol);
            end
        endcase
        for (int i = 0; i < NUM_COMP; i++) begin
            if (r[i] > COMP_MAX_L) begin
                r[i] = COMP_MAX_L;
                res.sat = 1'b1;
            end else if (r[i] < COMP_MIN_L) begin
                r[i] = COMP_MIN_L;
                res.sat = 1'b1;
            end
        end
        res.x = t_comp'(r[0]);
        res.y = t_comp'(r[1]);
        res.z = t_comp'(r[2]);
        res.w = t_comp'(r[3]);
        return res;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_quat_result want;
        if (!i_rst_n) begin
            eps_reg = EPS_RESET;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) eps_reg = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no pending item");
                    fail_cnt++;
                end else begin
                    want = result_q.pop_front();
                    check_field("res_x", want.x, i_res_x);
                    check_field("res_y", want.y, i_res_y);
                    check_field("res_z", want.z, i_res_z);
                    check_field("res_w", want.w, i_res_w);
                    check_field("equal_flag", want.eq, i_equal_flag);
                    check_field("saturated", want.sat, i_saturated);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(hamilton_predict(t_op'(i_opcode),
                    i_a_x, i_a_y, i_a_z, i_a_w, i_b_x, i_b_y, i_b_z, i_b_w, eps_reg));
            end
        end
        pending_cnt = result_q.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import qalu_pkg::*;

    localparam t_comp Q_MIN = {1'b1, {(COMP_WIDTH - 1){1'b0}}};
    localparam t_comp Q_MAX = {1'b0, {(COMP_WIDTH - 1){1'b1}}};
    localparam t_comp Q_ONE = t_comp'(1 << FRAC_BITS);

    logic                 i_clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           opcode;
    t_comp                a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_comp                res_x, res_y, res_z, res_w;
    logic                 equal_flag;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [EPS_WIDTH-1:0] cfg_data;
    int                   pending;
    int                   fail_count;

    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   cur_eps = 1;

    quaternion_alu_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_a_x        (a_x),
        .i_a_y        (a_y),
        .i_a_z        (a_z),
        .i_a_w        (a_w),
        .i_b_x        (b_x),
        .i_b_y        (b_y),
        .i_b_z        (b_z),
        .i_b_w        (b_w),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_res_x      (res_x),
        .o_res_y      (res_y),
        .o_res_z      (res_z),
        .o_res_w      (res_w),
        .o_equal_flag (equal_flag),
        .o_saturated  (saturated),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    qalu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_a_x        (a_x),
        .i_a_y        (a_y),
        .i_a_z        (a_z),
        .i_a_w        (a_w),
        .i_b_x        (b_x),
        .i_b_y        (b_y),
        .i_b_z        (b_z),
        .i_b_w        (b_w),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_res_x      (res_x),
        .i_res_y      (res_y),
        .i_res_z      (res_z),
        .i_res_w      (res_w),
        .i_equal_flag (equal_flag),
        .i_saturated  (saturated),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) out_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_op(t_op op, t_comp ax, t_comp ay, t_comp az, t_comp aw,
                           t_comp bx, t_comp by, t_comp bz, t_comp bw);
        logic stalled;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
        b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
        // stall is settled by the falling edge
        do begin
            @(negedge i_clk);
            stalled = in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_eps(int v);
        logic ready_seen;
        drain_results();
        repeat (6) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[EPS_WIDTH-1:0];
        do begin
            @(negedge i_clk);
            ready_seen = cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        cfg_valid <= 1'b0;
        cur_eps = v;
    endtask

    function automatic t_comp rand_comp();
        case ($urandom_range(9)) inside
            0:       return Q_MIN;
            1:       return Q_MAX;
            [2:4]:   return t_comp'($urandom_range(0, 2 << FRAC_BITS) - (1 << FRAC_BITS));
            default: return t_comp'($urandom);
        endcase
    endfunction

    // compare items often get b close to a so both flag values show up
    function automatic t_comp near_comp(t_comp base);
        int span;
        span = (cur_eps > 30000) ? 40000 : cur_eps + 2;
        return t_comp'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_random();
        t_op   op;
        t_comp ax, ay, az, aw, bx, by, bz, bw;
        op = t_op'($urandom_range(3));
        ax = rand_comp(); ay = rand_comp(); az = rand_comp(); aw = rand_comp();
        if (op == OP_CMP && $urandom_range(1) == 1) begin
            bx = near_comp(ax); by = near_comp(ay); bz = near_comp(az); bw = near_comp(aw);
        end else begin
            bx = rand_comp(); by = rand_comp(); bz = rand_comp(); bw = rand_comp();
        end
        send_op(op, ax, ay, az, aw, bx, by, bz, bw);
    endtask

    task automatic run_phase(int idle, int stall, int eps, int count);
        write_eps(eps);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_random();
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_MUL;
        a_x <= '0; a_y <= '0; a_z <= '0; a_w <= '0;
        b_x <= '0; b_y <= '0; b_z <= '0; b_w <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset epsilon of one
        send_op(OP_MUL, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE);
        send_op(OP_MUL, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0);
        send_op(OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_op(OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_op(OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        // rounding ties
        send_op(OP_MUL, 0, 0, 0, 1, 0, 0, 0, 8192);
        send_op(OP_MUL, 0, 0, 0, -1, 0, 0, 0, 8192);
        send_op(OP_MUL, 12345, -2222, 30000, -16384, -7, Q_MAX, Q_MIN, 9999);
        send_op(OP_CONJ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_op(OP_CONJ, Q_MAX, -5, 0, Q_MIN, 0, 0, 0, 0);
        send_op(OP_NEG, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
        send_op(OP_NEG, Q_MAX, 1, -1, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_op(OP_NEG, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_CMP, 100, -200, 300, Q_ONE, 100, -200, 300, Q_ONE);
        send_op(OP_CMP, 100, -200, 300, Q_ONE, 100, -200, 300, t_comp'(Q_ONE + 1));
        send_op(OP_CMP, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_op(OP_CMP, 0, 0, 0, 0, 0, 0, 0, 0);

        // zero tolerance never matches
        write_eps(0);
        send_op(OP_CMP, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_CMP, Q_MAX, Q_MIN, 7, -7, Q_MAX, Q_MIN, 7, -7);

        write_eps(32767);
        send_op(OP_CMP, 0, 0, 0, 0, 32766, 0, 0, 0);
        send_op(OP_CMP, 0, 0, 0, 0, 0, 0, Q_MAX, 0);
        send_op(OP_CMP, Q_MIN, 0, 0, 0, Q_MAX, 0, 0, 0);
        send_op(OP_CMP, -16384, 16382, -16384, 16382, 16382, -16384, 16382, -16384);

        run_phase(0, 0, 4, 125);
        run_phase(69, 0, 32767, 125);
        run_phase(0, 69, 0, 125);
        run_phase(23, 23, $urandom_range(32767), 125);

        drain_results();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/qalu_pkg.sv
rtl/core/quaternion_alu_core.sv
verif/qalu_checker.sv
verif/tb_top.sv
